/* sv/rti_pkg.sv */
package rti_pkg;

  localparam int IDX_W            = 10;
  localparam int COORD_W          = 32;
  localparam int EDGE_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * EDGE_W;
  localparam int CROSS_W          = PROD_W + 1;
  localparam int SPLIT_W          = 34;
  localparam int LO_W             = EDGE_W + SPLIT_W + 1;
  localparam int DOT_W            = 100;
  localparam int FRAC_W           = 16;
  localparam int NUM_W            = DOT_W + FRAC_W;
  localparam int QUOT_W           = 32;
  localparam int REM_W            = DOT_W + QUOT_W;
  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int QUEUE_DEPTH      = 2;
  localparam int LVL_W            = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ISECT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]          idx_t;

  localparam coord_t SAT_POS = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam coord_t SAT_NEG = coord_t'({1'b1, {(COORD_W-1){1'b0}}});

  typedef struct packed {
    logic   operation;
    idx_t   vertex_slot;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    idx_t   corner_a;
    idx_t   corner_b;
    idx_t   corner_c;
  } rti_in_t;

  typedef struct packed {
    logic   hit;
    coord_t bary_one;
    coord_t bary_two;
    coord_t ray_distance;
    logic   saturated;
  } rti_out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    vec_t v0;
    vec_t v1;
    vec_t v2;
    vec_t org;
    vec_t dir;
  } rti_job_t;

  typedef struct packed {
    logic             empty;
    logic [LVL_W-1:0] level;
  } rti_q_stat_t;

  typedef struct packed {
    logic                  zero_den;
    logic [2:0]            neg;
    logic [2:0][NUM_W-1:0] num;
    logic [DOT_W-1:0]      den;
  } rti_div_job_t;

endpackage

/* sv/rti_front.sv */
module rti_front import rti_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  rti_in_t  item,
  output logic     job_valid,
  output rti_job_t job
);

  localparam int DEPTH = (VERTEX_COUNT < (1 << IDX_W)) ? VERTEX_COUNT : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // one copy per corner so all three reads happen in the same cycle
  vec_t       mem_a_r [DEPTH];
  vec_t       mem_b_r [DEPTH];
  vec_t       mem_c_r [DEPTH];
  vec_t       rd_a_r, rd_b_r, rd_c_r, org_r, dir_r;
  logic [2:0] ok_r;
  logic       valid_r;
  logic       wr_en;
  vec_t       wr_vec;

  function automatic logic in_range(idx_t i);
    return int'(i) < VERTEX_COUNT;
  endfunction

  assign wr_en  = accept && (item.operation == OP_WRITE) && in_range(item.vertex_slot);
  assign wr_vec = {item.coord_x, item.coord_y, item.coord_z};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a_r[item.vertex_slot[AW-1:0]] <= wr_vec;
      mem_b_r[item.vertex_slot[AW-1:0]] <= wr_vec;
      mem_c_r[item.vertex_slot[AW-1:0]] <= wr_vec;
    end
    rd_a_r <= mem_a_r[item.corner_a[AW-1:0]];
    rd_b_r <= mem_b_r[item.corner_b[AW-1:0]];
    rd_c_r <= mem_c_r[item.corner_c[AW-1:0]];
    org_r  <= {item.coord_x, item.coord_y, item.coord_z};
    dir_r  <= {item.dir_x, item.dir_y, item.dir_z};
    ok_r   <= {in_range(item.corner_c), in_range(item.corner_b), in_range(item.corner_a)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept && (item.operation == OP_ISECT);
    end
  end

  // out-of-range corners read as the origin point
  assign job_valid = valid_r;
  assign job.v0    = ok_r[0] ? rd_a_r : '0;
  assign job.v1    = ok_r[1] ? rd_b_r : '0;
  assign job.v2    = ok_r[2] ? rd_c_r : '0;
  assign job.org   = org_r;
  assign job.dir   = dir_r;

endmodule

/* sv/rti_fifo.sv */
module rti_fifo import rti_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rti_job_t    push_job,
  input  logic        pop,
  output rti_job_t    head,
  output rti_q_stat_t stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  rti_job_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [LVL_W-1:0] level_r, level_nxt;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  assign level_nxt = level_r + LVL_W'(push) - LVL_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        wp_r <= bump(wp_r);
      end
      if (pop) begin
        rp_r <= bump(rp_r);
      end
      level_r <= level_nxt;
    end
  end

  assign head       = slot_r[rp_r];
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

endmodule

/* sv/rti_geom.sv */
module rti_geom import rti_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  rti_job_t     in_job,
  output logic         out_valid,
  output rti_div_job_t out_job
);

  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [LO_W-1:0]    lo_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  localparam int VE1 = 0;
  localparam int VE2 = 1;
  localparam int VD  = 2;
  localparam int VR  = 3;
  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};
  // dot products: divisor, then the three numerators
  localparam int DA [4] = '{VE1, VD, VR, VE2};
  localparam int DS [4] = '{0, 0, 1, 1};

  edge_t        vin_c [4][3];
  edge_t        vec_r [3][4][3];
  prod_t        pa1_r [3], pb1_r [3], pa2_r [3], pb2_r [3];
  cross_t       s1_r [3], s2_r [3];
  cross_t       sel_c [4][3];
  prod_t        hi_r [4][3];
  lo_t          lo_r [4][3];
  dot_t         term_r [4][3];
  dot_t         sum_r [4];
  rti_div_job_t ob_r;
  logic [6:0]   vld_r;

  function automatic logic [DOT_W-1:0] mag(dot_t v);
    return v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
  endfunction

  always_comb begin
    vin_c[VE1][0] = edge_t'(in_job.v1.x) - edge_t'(in_job.v0.x);
    vin_c[VE1][1] = edge_t'(in_job.v1.y) - edge_t'(in_job.v0.y);
    vin_c[VE1][2] = edge_t'(in_job.v1.z) - edge_t'(in_job.v0.z);
    vin_c[VE2][0] = edge_t'(in_job.v2.x) - edge_t'(in_job.v0.x);
    vin_c[VE2][1] = edge_t'(in_job.v2.y) - edge_t'(in_job.v0.y);
    vin_c[VE2][2] = edge_t'(in_job.v2.z) - edge_t'(in_job.v0.z);
    vin_c[VD][0]  = edge_t'(in_job.org.x) - edge_t'(in_job.v0.x);
    vin_c[VD][1]  = edge_t'(in_job.org.y) - edge_t'(in_job.v0.y);
    vin_c[VD][2]  = edge_t'(in_job.org.z) - edge_t'(in_job.v0.z);
    vin_c[VR][0]  = edge_t'(in_job.dir.x);
    vin_c[VR][1]  = edge_t'(in_job.dir.y);
    vin_c[VR][2]  = edge_t'(in_job.dir.z);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        sel_c[k][c] = (DS[k] == 0) ? s1_r[c] : s2_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    vec_r[0] <= vin_c;
    vec_r[1] <= vec_r[0];
    vec_r[2] <= vec_r[1];
    for (int i = 0; i < 3; i++) begin
      pa1_r[i] <= vec_r[0][VR][NX1[i]] * vec_r[0][VE2][NX2[i]];
      pb1_r[i] <= vec_r[0][VR][NX2[i]] * vec_r[0][VE2][NX1[i]];
      pa2_r[i] <= vec_r[0][VD][NX1[i]] * vec_r[0][VE1][NX2[i]];
      pb2_r[i] <= vec_r[0][VD][NX2[i]] * vec_r[0][VE1][NX1[i]];
      s1_r[i]  <= cross_t'(pa1_r[i]) - cross_t'(pb1_r[i]);
      s2_r[i]  <= cross_t'(pa2_r[i]) - cross_t'(pb2_r[i]);
    end
    // split the wide cross term into a signed top and an unsigned bottom part
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        hi_r[k][c]   <= vec_r[2][DA[k]][c] * $signed(sel_c[k][c][CROSS_W-1:SPLIT_W]);
        lo_r[k][c]   <= vec_r[2][DA[k]][c] * $signed({1'b0, sel_c[k][c][SPLIT_W-1:0]});
        term_r[k][c] <= (dot_t'(hi_r[k][c]) <<< SPLIT_W) + dot_t'(lo_r[k][c]);
      end
      sum_r[k] <= term_r[k][0] + term_r[k][1] + term_r[k][2];
    end
    ob_r.zero_den <= (sum_r[0] == '0);
    ob_r.den      <= mag(sum_r[0]);
    for (int n = 0; n < 3; n++) begin
      ob_r.neg[n] <= sum_r[n+1][DOT_W-1] ^ sum_r[0][DOT_W-1];
      ob_r.num[n] <= {mag(sum_r[n+1]), {FRAC_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  assign out_valid = vld_r[6];
  assign out_job   = ob_r;

endmodule

/* sv/rti_div.sv */
module rti_div import rti_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  rti_div_job_t in_job,
  output logic         out_valid,
  output rti_out_t     out_result
);

  localparam int NS = QUOT_W;

  logic [REM_W-1:0]  rem_r [NS+1][3];
  logic [QUOT_W-1:0] q_r [NS+1][3];
  logic [DOT_W-1:0]  den_r [NS+1];
  logic [2:0]        neg_r [NS+1];
  logic [2:0]        ovf_r [NS+1];
  logic [NS:0]       zero_r;
  logic [NS:0]       vld_r;
  logic [REM_W-1:0]  dsh_c [NS];
  logic              ge_c [NS][3];
  coord_t            val_c [3];
  logic [2:0]        sat_c;
  rti_out_t          out_r;
  logic              out_valid_r;

  always_comb begin
    for (int g = 0; g < NS; g++) begin
      dsh_c[g] = REM_W'(den_r[g]) << (NS - 1 - g);
      for (int k = 0; k < 3; k++) begin
        ge_c[g][k] = (rem_r[g][k] >= dsh_c[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    // quotient of 2^32 or more saturates regardless of sign
    for (int k = 0; k < 3; k++) begin
      rem_r[0][k] <= REM_W'(in_job.num[k]);
      q_r[0][k]   <= '0;
      ovf_r[0][k] <= (REM_W'(in_job.num[k]) >> QUOT_W) >= REM_W'(in_job.den);
    end
    den_r[0]  <= in_job.den;
    neg_r[0]  <= in_job.neg;
    zero_r[0] <= in_job.zero_den;
    for (int g = 0; g < NS; g++) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[g+1][k] <= ge_c[g][k] ? (rem_r[g][k] - dsh_c[g]) : rem_r[g][k];
        q_r[g+1][k]   <= q_r[g][k] | (QUOT_W'(ge_c[g][k]) << (NS - 1 - g));
      end
      den_r[g+1]  <= den_r[g];
      neg_r[g+1]  <= neg_r[g];
      ovf_r[g+1]  <= ovf_r[g];
      zero_r[g+1] <= zero_r[g];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!neg_r[NS][k]) begin
        sat_c[k] = ovf_r[NS][k] || q_r[NS][k][QUOT_W-1];
        val_c[k] = sat_c[k] ? SAT_POS : coord_t'(q_r[NS][k]);
      end else begin
        sat_c[k] = ovf_r[NS][k] || (q_r[NS][k][QUOT_W-1] && (q_r[NS][k][QUOT_W-2:0] != '0));
        val_c[k] = sat_c[k] ? SAT_NEG : coord_t'(-q_r[NS][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r.hit          <= !zero_r[NS];
    out_r.bary_one     <= zero_r[NS] ? '0 : val_c[0];
    out_r.bary_two     <= zero_r[NS] ? '0 : val_c[1];
    out_r.ray_distance <= zero_r[NS] ? '0 : val_c[2];
    out_r.saturated    <= !zero_r[NS] && (sat_c != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[NS-1:0], in_valid};
      out_valid_r <= vld_r[NS];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

/* sv/ray_triangle_intersection.sv */
// Moller-Trumbore ray/triangle test over an internal vertex memory.
// Input channel: start with in_item; an item transfers at a rising edge with
// start high and busy low. operation OP_WRITE stores one Q16.16 vertex at
// vertex_slot (slots at or beyond VERTEX_COUNT are dropped) and gives no
// result. OP_ISECT reads corners a/b/c and tests the ray (coord = origin,
// dir = direction); corners at or beyond VERTEX_COUNT read as zero.
// Result channel: out_valid is high for exactly one cycle per intersect item
// with out_result; results come back in input order. The receiver cannot
// stall, so nothing backs up from the result side.
// Path from the transfer edge to the result: vertex read, a two-entry queue,
// seven arithmetic stages (edge, cross and dot products), one overflow check
// and 32 restoring-division stages, one bit of quotient each, with the three
// quotients in parallel, then an output stage.
// Throughput: one item per cycle; busy only rises if the queue fills.
// A write is seen by an intersect item accepted in the very next cycle.
// Reset (rst_n low, synchronous) flushes all items in flight; the vertex
// memory keeps its contents and is undefined until written.
module ray_triangle_intersection import rti_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rti_in_t  in_item,
  output logic     out_valid,
  output rti_out_t out_result
);

  logic         accept;
  logic         job_valid;
  rti_job_t     job;
  rti_job_t     head;
  rti_q_stat_t  stat;
  logic         pop;
  logic         dv_valid;
  rti_div_job_t dv_job;
  logic [LVL_W:0] proj;

  assign accept = start && !busy;
  assign pop    = !stat.empty;
  // level after this edge, counting the item still at the memory read
  assign proj   = (LVL_W+1)'(stat.level) - (LVL_W+1)'(pop) + (LVL_W+1)'(job_valid);
  assign busy   = (int'(proj) >= QUEUE_DEPTH);

  rti_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .job_valid (job_valid),
    .job       (job)
  );

  rti_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  rti_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pop),
    .in_job    (head),
    .out_valid (dv_valid),
    .out_job   (dv_job)
  );

  rti_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dv_valid),
    .in_job     (dv_job),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

/* sv/rti_checker.sv */
module rti_checker import rti_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input rti_out_t out_result
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised although the back end never stalls");

  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_result.hit |->
      out_result.bary_one == '0 && out_result.bary_two == '0 &&
      out_result.ray_distance == '0 && !out_result.saturated)
    else $error("parallel ray with nonzero fields");

  a_sat_hit: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_result.saturated |-> out_result.hit)
    else $error("saturation flagged on a miss");

endmodule

bind ray_triangle_intersection rti_checker u_rti_checker (.*);
